// ===== sv/kred_pkg.sv =====
// shared types and constants for the key report edge detector
`default_nettype none
package kred_pkg;
  localparam int KEY_SLOTS_DEF   = 16;
  localparam int EVENT_LIMIT_DEF = 32;

  localparam logic [2:0] ST_EVENT        = 3'd0;
  localparam logic [2:0] ST_NO_CHANGE    = 3'd1;
  localparam logic [2:0] ST_DEFERRED     = 3'd2;
  localparam logic [2:0] ST_NO_SAMPLE    = 3'd3;
  localparam logic [2:0] ST_BAD_CAPACITY = 3'd4;

  localparam logic CMD_SLOT = 1'b0;
  localparam logic CMD_EOP  = 1'b1;

  typedef struct packed {
    logic        command;
    logic [15:0] key_code;
    logic        connected;
    logic        intercepted;
    logic [7:0]  capacity;
  } in_req_t;

  typedef struct packed {
    logic [15:0] usage_code;
    logic        is_press;
    logic [2:0]  status;
    logic        last;
  } out_req_t;

  // controller to datapath
  typedef struct packed {
    logic slot_add;
    logic clear_union;
    logic clear_scan;
    logic load_cap;
    logic scan_step;
    logic count_only;
    logic emit_status;
    logic [2:0] status;
    logic commit;
  } kred_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic report_seen;
    logic scan_done;
    logic needed_zero;
    logic over_cap;
    logic emit_done;
  } kred_sts_t;
endpackage
`default_nettype wire

// ===== sv/kred_ctrl.sv =====
// controller state machine for the key report edge detector
`default_nettype none
module kred_ctrl
  import kred_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  input  wire logic      in_command,
  input  wire logic [7:0] in_capacity,
  output logic           busy,
  output kred_cmd_t      cmd,
  input  wire kred_sts_t sts
);
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_COUNT = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_EMIT  = 3'd3;
  localparam logic [2:0] S_SLOT  = 3'd4;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    busy = (state_r != S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_command == CMD_SLOT) begin
            cmd.slot_add = 1'b1;
            state_nxt = S_SLOT;
          end else if (in_capacity == 8'd0) begin
            cmd.emit_status = 1'b1;
            cmd.status = ST_BAD_CAPACITY;
            cmd.clear_union = 1'b1;
            state_nxt = S_SLOT;
          end else if (!sts.report_seen) begin
            cmd.emit_status = 1'b1;
            cmd.status = ST_NO_SAMPLE;
            cmd.clear_union = 1'b1;
            state_nxt = S_SLOT;
          end else begin
            cmd.clear_scan = 1'b1;
            cmd.load_cap = 1'b1;
            state_nxt = S_COUNT;
          end
        end
      end
      S_COUNT: begin
        cmd.scan_step = 1'b1;
        cmd.count_only = 1'b1;
        if (sts.scan_done) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.clear_scan = 1'b1;
        if (sts.needed_zero) begin
          cmd.emit_status = 1'b1;
          cmd.status = ST_NO_CHANGE;
          cmd.clear_union = 1'b1;
          state_nxt = S_SLOT;
        end else if (sts.over_cap) begin
          cmd.emit_status = 1'b1;
          cmd.status = ST_DEFERRED;
          cmd.clear_union = 1'b1;
          state_nxt = S_SLOT;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        cmd.scan_step = 1'b1;
        if (sts.emit_done) begin
          cmd.commit = 1'b1;
          cmd.clear_union = 1'b1;
          state_nxt = S_SLOT;
        end
      end
      S_SLOT: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTHESIS
  a_emit_from_check: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> ($past(state_r) == S_CHECK || $past(state_r) == S_EMIT))
    else $error("emit entered out of order");
  a_slot_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SLOT) |=> (state_r == S_IDLE))
    else $error("slot state stuck");
  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !cmd.slot_add)
    else $error("slot added while busy");
`endif
endmodule
`default_nettype wire

// ===== sv/kred_dp.sv =====
// union, history and scan datapath for the key report edge detector
`default_nettype none
module kred_dp
  import kred_pkg::*;
#(
  parameter int KEY_SLOTS   = KEY_SLOTS_DEF,
  parameter int EVENT_LIMIT = EVENT_LIMIT_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire in_req_t   in_req,
  input  wire kred_cmd_t cmd,
  output kred_sts_t      sts,
  output logic           out_valid,
  output out_req_t       out_req
);
  localparam int IW = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
  localparam int CW = $clog2(KEY_SLOTS + 1);
  localparam int SW = $clog2(2 * KEY_SLOTS + 1);
  localparam int NW = $clog2(2 * KEY_SLOTS + 1);
  localparam int EW = $clog2(EVENT_LIMIT + 1);

  logic [15:0] union_r [KEY_SLOTS];
  logic [15:0] hist_r  [KEY_SLOTS];
  logic [CW-1:0] ucnt_r;
  logic seen_r;
  logic [SW-1:0] scan_r;
  logic [NW-1:0] need_r;
  logic [NW-1:0] emitted_r;
  logic [EW-1:0] cap_r;
  logic out_valid_r;
  out_req_t out_r;

  logic in_union, in_hist_cur, in_union_cur;
  logic phase_rel;
  logic [IW-1:0] idx;
  logic [15:0] cur;
  logic change;

  always_comb begin
    in_union = 1'b0;
    for (int i = 0; i < KEY_SLOTS; i++) begin
      if (union_r[i] == in_req.key_code) in_union = 1'b1;
    end
  end

  assign phase_rel = (scan_r < SW'(KEY_SLOTS));
  assign idx = phase_rel ? scan_r[IW-1:0] : IW'(scan_r - SW'(KEY_SLOTS));
  assign cur = phase_rel ? hist_r[idx] : union_r[idx];

  always_comb begin
    in_hist_cur = 1'b0;
    in_union_cur = 1'b0;
    for (int i = 0; i < KEY_SLOTS; i++) begin
      if (hist_r[i] == cur) in_hist_cur = 1'b1;
      if (union_r[i] == cur) in_union_cur = 1'b1;
    end
  end

  assign change = (cur != 16'd0) && (phase_rel ? !in_union_cur : !in_hist_cur);

  assign sts.report_seen = seen_r;
  assign sts.scan_done   = (scan_r == SW'(2 * KEY_SLOTS - 1));
  assign sts.needed_zero = (need_r == '0);
  assign sts.over_cap    = (32'(need_r) > 32'(cap_r));
  assign sts.emit_done   = (scan_r == SW'(2 * KEY_SLOTS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < KEY_SLOTS; i++) begin
        union_r[i] <= '0;
        hist_r[i]  <= '0;
      end
      ucnt_r <= '0;
      seen_r <= 1'b0;
      scan_r <= '0;
      need_r <= '0;
      emitted_r <= '0;
      cap_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (cmd.slot_add) begin
        seen_r <= 1'b1;
        if (in_req.connected && !in_req.intercepted && in_req.key_code != 16'd0
            && !in_union && ucnt_r < CW'(KEY_SLOTS)) begin
          union_r[ucnt_r[IW-1:0]] <= in_req.key_code;
          ucnt_r <= ucnt_r + CW'(1);
        end
      end
      if (cmd.clear_scan) begin
        scan_r <= '0;
        emitted_r <= '0;
      end
      if (cmd.load_cap) begin
        need_r <= '0;
        cap_r <= (in_req.capacity > 8'(EVENT_LIMIT)) ? EW'(EVENT_LIMIT)
                                                      : EW'(in_req.capacity);
      end
      if (cmd.scan_step) begin
        scan_r <= scan_r + SW'(1);
        if (cmd.count_only) begin
          if (change) need_r <= need_r + NW'(1);
        end else if (change) begin
          out_valid_r <= 1'b1;
          out_r.usage_code <= cur;
          out_r.is_press <= !phase_rel;
          out_r.status <= ST_EVENT;
          out_r.last <= ((emitted_r + NW'(1)) == need_r);
          emitted_r <= emitted_r + NW'(1);
        end
      end
      if (cmd.emit_status) begin
        out_valid_r <= 1'b1;
        out_r.usage_code <= '0;
        out_r.is_press <= 1'b0;
        out_r.status <= cmd.status;
        out_r.last <= 1'b1;
      end
      if (cmd.commit) begin
        for (int i = 0; i < KEY_SLOTS; i++) hist_r[i] <= union_r[i];
      end
      if (cmd.clear_union) begin
        for (int i = 0; i < KEY_SLOTS; i++) union_r[i] <= '0;
        ucnt_r <= '0;
        seen_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_req = out_r;

`ifndef SYNTHESIS
  a_union_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ucnt_r <= CW'(KEY_SLOTS)) else $error("union overfilled");
  a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    emitted_r <= need_r || cmd.count_only) else $error("too many events");
  a_clear_seen: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear_union |=> !seen_r) else $error("sample flag not cleared");
`endif
endmodule
`default_nettype wire

// ===== sv/key_report_edge_detector.sv =====
// Key report edge detector: slot requests (command 0) pass through the slot
// state and build a deduplicated union of pressed keys. An end-of-poll request
// ends in a bad-capacity or no-sample status from idle, in a no-change or
// deferred status after the count walk, or in events from the emit walk that
// follows it; both walks use the shared scan counter that visits history then
// union one entry a cycle. Results come one cycle each on out_valid and the
// receiver cannot stall them; busy stays high until the run ends, and start
// is taken only while busy is low.
`default_nettype none
module key_report_edge_detector
  import kred_pkg::*;
#(
  parameter int KEY_SLOTS   = KEY_SLOTS_DEF,
  parameter int EVENT_LIMIT = EVENT_LIMIT_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    start,
  output logic         busy,
  input  wire in_req_t in_req,
  output logic         out_valid,
  output out_req_t     out_req
);
  kred_cmd_t cmd;
  kred_sts_t sts;

  kred_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start),
    .in_command(in_req.command), .in_capacity(in_req.capacity),
    .busy(busy), .cmd(cmd), .sts(sts)
  );

  kred_dp #(.KEY_SLOTS(KEY_SLOTS), .EVENT_LIMIT(EVENT_LIMIT)) u_dp (
    .clk(clk), .rst_n(rst_n), .in_req(in_req), .cmd(cmd), .sts(sts),
    .out_valid(out_valid), .out_req(out_req)
  );
endmodule
`default_nettype wire
